>>> rtl/isf_pkg.sv
package isf_pkg;

    localparam int STORE_DEPTH = 64;
    localparam int KEY_W       = 16;
    localparam int CNT_W       = $clog2(STORE_DEPTH + 1);

    typedef struct packed {
        logic signed [KEY_W-1:0] key_in;
        logic                    list_end;
    } key_beat_t;

    typedef struct packed {
        logic signed [KEY_W-1:0] key_out;
        logic                    is_final;
        logic                    overflowed;
    } sort_beat_t;

    typedef struct packed {
        logic ins;
        logic shl;
    } cell_ctl_t;

    typedef enum logic {
        ST_COLLECT,
        ST_DUMP
    } state_t;

endpackage

>>> rtl/isf_cell.sv
module isf_cell (
    input  logic                              clk,
    input  isf_pkg::cell_ctl_t                ctl,
    input  logic signed [isf_pkg::KEY_W-1:0]  new_key,
    input  logic                              valid,
    input  logic                              lower_valid,
    input  logic                              lower_gt,
    input  logic signed [isf_pkg::KEY_W-1:0]  lower_key,
    input  logic signed [isf_pkg::KEY_W-1:0]  upper_key,
    output logic signed [isf_pkg::KEY_W-1:0]  key,
    output logic                              gt
);
    import isf_pkg::*;

    logic signed [KEY_W-1:0] key_reg;
    logic signed [KEY_W-1:0] key_next;

    assign key = key_reg;
    assign gt  = valid && (key_reg > new_key);

    always_comb
    begin
        key_next = key_reg;
        if (ctl.ins)
        begin
            if (lower_gt)
            begin
                key_next = lower_key;
            end
            else if (gt || (!valid && lower_valid))
            begin
                key_next = new_key;
            end
        end
        else if (ctl.shl)
        begin
            key_next = upper_key;
        end
    end

    always_ff @(posedge clk)
    begin
        key_reg <= key_next;
    end

endmodule

>>> rtl/insertion_sorter.sv
// Stable insertion sorter for signed 16-bit keys, built as a row of STORE_DEPTH cells.
// While a list is being collected one key is taken per cycle: every cell compares
// against the incoming key at once and the larger keys step up by one cell, so equal
// keys keep their arrival order. The beat flagged list_end is inserted too, and in the
// following cycles the row shifts down toward cell 0 and emits one sorted beat per
// cycle while sort_stall is low, ascending, with is_final on the last one; key_stall
// stays high after the final key until every stored key has been emitted.
// Keys arriving while all STORE_DEPTH cells are filled are dropped, and every beat of
// that list carries overflowed. A new list may be taken while the last sorted beat
// still waits in the output register.
module insertion_sorter (
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    key_valid,
    output logic                    key_stall,
    input  isf_pkg::key_beat_t      key_beat,
    output logic                    sort_valid,
    input  logic                    sort_stall,
    output isf_pkg::sort_beat_t     sort_beat
);
    import isf_pkg::*;

    state_t                  state_reg;
    state_t                  state_next;
    logic [CNT_W-1:0]        key_count_reg;
    logic [CNT_W-1:0]        key_count_next;
    logic                    drop_reg;
    logic                    drop_next;
    logic                    out_valid_reg;
    logic                    out_valid_next;
    sort_beat_t              out_beat_reg;
    sort_beat_t              out_beat_next;

    logic                    key_acc;
    logic                    load;
    logic                    full;
    cell_ctl_t               ctl;

    logic                    cell_valid [STORE_DEPTH];
    logic                    cell_gt    [STORE_DEPTH];
    logic signed [KEY_W-1:0] cell_key   [STORE_DEPTH];

    assign key_acc   = key_valid && !key_stall;
    assign full      = (key_count_reg == CNT_W'(STORE_DEPTH));
    assign load      = (state_reg == ST_DUMP) && (!out_valid_reg || !sort_stall);
    assign ctl.ins   = key_acc && !full;
    assign ctl.shl   = load;

    assign key_stall  = (state_reg != ST_COLLECT);
    assign sort_valid = out_valid_reg;
    assign sort_beat  = out_beat_reg;

    // row of cells, cell 0 holds the smallest key
    for (genvar i = 0; i < STORE_DEPTH; i++)
    begin : g_cell
        logic                    lv;
        logic                    lg;
        logic signed [KEY_W-1:0] lk;
        logic signed [KEY_W-1:0] uk;

        assign cell_valid[i] = (key_count_reg > CNT_W'(i));

        if (i == 0)
        begin : g_first
            assign lv = 1'b1;
            assign lg = 1'b0;
            assign lk = key_beat.key_in;
        end
        else
        begin : g_mid
            assign lv = cell_valid[i-1];
            assign lg = cell_gt[i-1];
            assign lk = cell_key[i-1];
        end

        if (i == STORE_DEPTH - 1)
        begin : g_last
            assign uk = cell_key[i];
        end
        else
        begin : g_up
            assign uk = cell_key[i+1];
        end

        isf_cell u_cell (
            .clk         (clk),
            .ctl         (ctl),
            .new_key     (key_beat.key_in),
            .valid       (cell_valid[i]),
            .lower_valid (lv),
            .lower_gt    (lg),
            .lower_key   (lk),
            .upper_key   (uk),
            .key         (cell_key[i]),
            .gt          (cell_gt[i])
        );
    end

    always_comb
    begin
        state_next     = state_reg;
        key_count_next = key_count_reg;
        drop_next      = drop_reg;
        out_valid_next = out_valid_reg && sort_stall;
        out_beat_next  = out_beat_reg;
        case (state_reg)
            ST_COLLECT:
            begin
                if (key_acc)
                begin
                    if (full)
                    begin
                        drop_next = 1'b1;
                    end
                    else
                    begin
                        key_count_next = key_count_reg + CNT_W'(1);
                    end
                    if (key_beat.list_end)
                    begin
                        state_next = ST_DUMP;
                    end
                end
            end
            ST_DUMP:
            begin
                if (load)
                begin
                    out_valid_next           = 1'b1;
                    out_beat_next.key_out    = cell_key[0];
                    out_beat_next.is_final   = (key_count_reg == CNT_W'(1));
                    out_beat_next.overflowed = drop_reg;
                    key_count_next           = key_count_reg - CNT_W'(1);
                    if (key_count_reg == CNT_W'(1))
                    begin
                        drop_next  = 1'b0;
                        state_next = ST_COLLECT;
                    end
                end
            end
            default:
            begin
                state_next = ST_COLLECT;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_COLLECT;
            key_count_reg <= '0;
            drop_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            key_count_reg <= key_count_next;
            drop_reg      <= drop_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_beat_reg <= out_beat_next;
    end

    a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
        key_count_reg <= CNT_W'(STORE_DEPTH))
        else $error("key count above store depth");

    a_dump_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
        (key_acc && key_beat.list_end) |=> (state_reg == ST_DUMP && key_count_reg != '0))
        else $error("dump started with empty store");

    a_dump_done: assert property (@(posedge clk) disable iff (!rst_n)
        (load && key_count_reg == CNT_W'(1)) |=> (state_reg == ST_COLLECT && key_count_reg == '0))
        else $error("dump did not finish after last beat");

    a_row_sorted: assert property (@(posedge clk) disable iff (!rst_n)
        cell_valid[1] |-> (cell_key[0] <= cell_key[1]))
        else $error("lowest cells out of order");

endmodule

>>> tb/sv/tb_insertion_sorter.sv
`timescale 1ns / 1ps

module tb_insertion_sorter;
    import isf_pkg::*;

    localparam int RANDOM_KEYS = 310;

    logic       clk = 1'b0;
    logic       rst_n = 1'b0;
    logic       key_valid = 1'b0;
    logic       key_stall;
    key_beat_t  key_beat = '0;
    logic       sort_valid;
    logic       sort_stall = 1'b0;
    sort_beat_t sort_beat;

    // predictor state
    logic signed [KEY_W-1:0] kept_keys [STORE_DEPTH];
    int unsigned             kept_count = 0;
    bit                      keys_lost = 1'b0;
    sort_beat_t              pending_sorted [$];

    bit quiet = 1'b0;
    int hold_left = 0;
    int errors = 0;
    int keys_sent = 0;
    int lists_sent = 0;
    int beats_checked = 0;
    int overflow_lists = 0;

    insertion_sorter DUT (
        .clk        (clk),
        .rst_n      (rst_n),
        .key_valid  (key_valid),
        .key_stall  (key_stall),
        .key_beat   (key_beat),
        .sort_valid (sort_valid),
        .sort_stall (sort_stall),
        .sort_beat  (sort_beat)
    );

    always #5 clk = ~clk;

    function automatic int pick_gap(bit no_idle);
        int r;
        if (no_idle)
            return 0;
        r = $urandom_range(0, 99);
        if (r < 55)
            return 0;
        if (r < 92)
            return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    function automatic logic signed [KEY_W-1:0] rand_key();
        case ($urandom_range(0, 5))
            0: return ($urandom_range(0, 1) != 0) ? 16'sh7FFF : 16'sh8000;
            1: return KEY_W'($signed($urandom_range(0, 8)) - 4);
            default: return KEY_W'($urandom);
        endcase
    endfunction

    // stable insert; dump the whole list on the final key
    function automatic void sort_key_in(key_beat_t b);
        int pos;
        sort_beat_t r;
        if (kept_count < STORE_DEPTH)
        begin
            pos = kept_count;
            while (pos > 0 && kept_keys[pos-1] > b.key_in)
            begin
                kept_keys[pos] = kept_keys[pos-1];
                pos--;
            end
            kept_keys[pos] = b.key_in;
            kept_count++;
        end
        else
        begin
            keys_lost = 1'b1;
        end
        if (b.list_end)
        begin
            for (int i = 0; i < kept_count; i++)
            begin
                r.key_out    = kept_keys[i];
                r.is_final   = (i + 1 == kept_count);
                r.overflowed = keys_lost;
                pending_sorted.push_back(r);
            end
            if (keys_lost)
                overflow_lists++;
            lists_sent++;
            kept_count = 0;
            keys_lost  = 1'b0;
        end
    endfunction

    task automatic report(input string what, input int got, input int want);
        $display("%0t mismatch %s: got %0d expected %0d", $time, what, got, want);
        errors++;
    endtask

    task automatic check_sorted(input sort_beat_t got);
        sort_beat_t want;
        if (pending_sorted.size() == 0)
        begin
            report("unexpected sorted beat, key_out", got.key_out, 0);
            return;
        end
        want = pending_sorted.pop_front();
        beats_checked++;
        if (got.key_out !== want.key_out)
            report("key_out", got.key_out, want.key_out);
        if (got.is_final !== want.is_final)
            report("is_final", got.is_final, want.is_final);
        if (got.overflowed !== want.overflowed)
            report("overflowed", got.overflowed, want.overflowed);
    endtask

    // output side: check each accepted beat, stall at random
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sort_stall <= 1'b0;
            hold_left = 0;
        end
        else
        begin
            if (sort_valid && !sort_stall)
                check_sorted(sort_beat);
            if (hold_left > 0)
            begin
                sort_stall <= 1'b1;
                hold_left--;
            end
            else
            begin
                hold_left = pick_gap(quiet);
                sort_stall <= (hold_left > 0);
                if (hold_left > 0)
                    hold_left--;
            end
        end
    end

    task automatic send_key(input logic signed [KEY_W-1:0] k, input logic last);
        int gap;
        key_beat_t b;
        gap = pick_gap(quiet);
        b.key_in   = k;
        b.list_end = last;
        if (gap > 0)
        begin
            key_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        key_valid <= 1'b1;
        key_beat  <= b;
        do @(posedge clk); while (key_stall);
        sort_key_in(b);
        keys_sent++;
    endtask

    task automatic send_list(input int len);
        for (int i = 0; i < len; i++)
            send_key(rand_key(), i == len - 1);
    endtask

    task automatic test_directed();
        // single-key lists at both extremes
        send_key(16'sh7FFF, 1'b1);
        send_key(16'sh8000, 1'b1);
        // extremes with repeats
        send_key(16'sh7FFF, 1'b0);
        send_key(16'sh8000, 1'b0);
        send_key(16'sh0000, 1'b0);
        send_key(-16'sd1, 1'b0);
        send_key(16'sd1, 1'b0);
        send_key(16'sh7FFF, 1'b0);
        send_key(16'sh8000, 1'b0);
        send_key(16'sh0000, 1'b1);
        // repeated equal keys with a smaller key among them
        send_key(16'sd5, 1'b0);
        send_key(16'sd5, 1'b0);
        send_key(16'sd5, 1'b0);
        send_key(-16'sd5, 1'b0);
        send_key(16'sd5, 1'b1);
        // descending arrival: every later insert shifts the row
        send_key(16'sd3, 1'b0);
        send_key(16'sd2, 1'b0);
        send_key(16'sd1, 1'b0);
        send_key(16'sd0, 1'b1);
        // already sorted
        send_key(16'sd0, 1'b0);
        send_key(16'sd1, 1'b0);
        send_key(16'sd2, 1'b1);
    endtask

    task automatic test_full_store();
        // exactly full, then full with the tail and the final key dropped
        send_list(STORE_DEPTH);
        quiet = 1'b1;
        send_list(STORE_DEPTH + 2);
        quiet = 1'b0;
    endtask

    task automatic test_random_lists();
        while (keys_sent < RANDOM_KEYS)
        begin
            quiet = ($urandom_range(0, 3) == 0);
            send_list($urandom_range(1, 14));
        end
        quiet = 1'b0;
    endtask

    initial
    begin
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_directed();
        test_full_store();
        test_random_lists();
        key_valid <= 1'b0;
        while (pending_sorted.size() != 0)
            @(posedge clk);
        repeat (STORE_DEPTH + 8) @(posedge clk);
        $display("sent %0d keys in %0d lists (%0d with dropped keys), checked %0d sorted beats",
                 keys_sent, lists_sent, overflow_lists, beats_checked);
        if (errors == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

    initial
    begin
        #5_000_000;
        $display("timeout with %0d sorted beats still pending", pending_sorted.size());
        $display("Verification failed");
        $finish;
    end

endmodule
